[hw/rtl/sbpb_pkg.sv]
// Shared constants, types and register codes for the spectrum bar/peak ballistics block.
package sbpb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned BIN_COUNT_DEF     = 64;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned BIN_W     = 6;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned OUT_LVL_W = 17;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Level mapping: product is 16x16, result scaled down by 2^MAP_SHIFT
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned MAP_SHIFT   = 24;
  // Decay factors are Q0.16
  localparam int unsigned DECAY_SHIFT = 16;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] FLOOR_RST      = 16'hC400; // -15360
  localparam logic [CFG_W-1:0] SCALE_RST      = 16'd1092;
  localparam logic [CFG_W-1:0] BAR_DECAY_RST  = 16'd60000;
  localparam logic [CFG_W-1:0] PEAK_DECAY_RST = 16'd64000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR_LEVEL = 2'd0,
    REG_LEVEL_SCALE = 2'd1,
    REG_BAR_DECAY   = 2'd2,
    REG_PEAK_DECAY  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_SET  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  // Classified command handed from front to back
  typedef struct packed {
    logic             tick;
    logic             wr;
    logic [BIN_W-1:0] bin;
  } cmd_ctl_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] floor_level;
    logic [CFG_W-1:0]        level_scale;
  } map_cfg_t;

  typedef struct packed {
    logic [CFG_W-1:0] bar_decay;
    logic [CFG_W-1:0] peak_decay;
  } decay_cfg_t;

endpackage

[hw/rtl/sbpb_intf.sv]
// Valid/ready channel interfaces for the input, result and configuration ports.
interface sbpb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic [sbpb_pkg::BIN_W-1:0]           bin_index;
  logic signed [sbpb_pkg::LEVEL_W-1:0]  level_db;

  modport source (output valid, mode, bin_index, level_db, input ready);
  modport sink   (input valid, mode, bin_index, level_db, output ready);
endinterface

interface sbpb_out_if;
  logic                               valid;
  logic                               ready;
  logic [sbpb_pkg::BIN_W-1:0]         out_bin;
  logic [sbpb_pkg::OUT_LVL_W-1:0]     bar_level;
  logic [sbpb_pkg::OUT_LVL_W-1:0]     peak_level;
  logic                               last_bin;

  modport source (output valid, out_bin, bar_level, peak_level, last_bin, input ready);
  modport sink   (input valid, out_bin, bar_level, peak_level, last_bin, output ready);
endinterface

interface sbpb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sbpb_pkg::CFG_IDX_W-1:0]     index;
  logic [sbpb_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/sbpb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/sbpb_fifo.sv]
// Short command queue between the front and back parts.
module sbpb_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = sbpb_pkg::QUEUE_DEPTH,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]   CNT_FULL = (PW + 1)'(DEPTH);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/sbpb_front.sv]
// Front part: accepts input beats, classifies them and maps dB levels to fractions.
module sbpb_front #(
  parameter int unsigned BIN_COUNT     = sbpb_pkg::BIN_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = sbpb_pkg::FRACTION_BITS_DEF,
  localparam int unsigned LW           = FRACTION_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sbpb_in_if.sink            in_i,
  input  sbpb_pkg::map_cfg_t cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output sbpb_pkg::cmd_ctl_t push_ctl_o,
  output logic [LW-1:0]      push_target_o
);

  localparam int unsigned    BW      = sbpb_pkg::BIN_W;
  localparam int unsigned    PW      = sbpb_pkg::PROD_W;
  localparam int unsigned    MAP_SHR = sbpb_pkg::MAP_SHIFT - FRACTION_BITS;
  localparam logic [BW-1:0]  LAST_BIN = BW'(BIN_COUNT - 1);
  localparam logic [BW:0]    BIN_LIM  = (BW + 1)'(BIN_COUNT);
  localparam logic [LW-1:0]  ONE_LVL  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [PW-1:0]  ONE_WIDE = PW'(ONE_LVL);

  logic               stg_vld_q;
  sbpb_pkg::cmd_ctl_t stg_ctl_q, ctl_d;
  logic [PW-1:0]      stg_prod_q, prod_d;
  logic               accept;
  logic               in_range;
  logic signed [sbpb_pkg::LEVEL_W:0] diff;
  logic               diff_pos;
  logic [PW-1:0]      frac_w;

  assign in_i.ready = !stg_vld_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // classify and multiply above the floor
  always_comb begin
    in_range  = ({1'b0, in_i.bin_index} < BIN_LIM);
    ctl_d.tick = (in_i.mode == sbpb_pkg::MODE_TICK);
    ctl_d.wr   = !ctl_d.tick && in_range;
    ctl_d.bin  = in_range ? in_i.bin_index : LAST_BIN;
    diff       = $signed({in_i.level_db[sbpb_pkg::LEVEL_W-1], in_i.level_db})
               - $signed({cfg_i.floor_level[sbpb_pkg::CFG_W-1], cfg_i.floor_level});
    diff_pos   = !diff[sbpb_pkg::LEVEL_W] && (diff != '0);
    prod_d     = diff_pos ? PW'(diff[sbpb_pkg::LEVEL_W-1:0]) * PW'(cfg_i.level_scale) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (accept) begin
      stg_vld_q <= 1'b1;
    end else if (push_ready_i) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_ctl_q  <= ctl_d;
      stg_prod_q <= prod_d;
    end
  end

  // scale down and saturate to full scale
  assign frac_w        = stg_prod_q >> MAP_SHR;
  assign push_valid_o  = stg_vld_q;
  assign push_ctl_o    = stg_ctl_q;
  assign push_target_o = (frac_w >= ONE_WIDE) ? ONE_LVL : frac_w[LW-1:0];

endmodule

[hw/rtl/sbpb_back.sv]
// Back part: per-bin read-modify-write sequencer over the level store, with output register.
module sbpb_back #(
  parameter int unsigned BIN_COUNT     = sbpb_pkg::BIN_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = sbpb_pkg::FRACTION_BITS_DEF,
  localparam int unsigned LW           = FRACTION_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  sbpb_pkg::cmd_ctl_t   pop_ctl_i,
  input  logic [LW-1:0]        pop_target_i,
  input  sbpb_pkg::decay_cfg_t cfg_i,
  sbpb_out_if.source           out_o
);

  localparam int unsigned   BW     = sbpb_pkg::BIN_W;
  localparam int unsigned   AW     = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned   ENT_W  = 3 * LW;
  localparam int unsigned   MUL_W  = LW + sbpb_pkg::DECAY_SHIFT;
  localparam int unsigned   OW     = sbpb_pkg::OUT_LVL_W;
  localparam int unsigned   EXT_W  = (LW > OW) ? LW : OW;
  localparam logic [BW-1:0] LAST_BIN = BW'(BIN_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC
  } state_e;

  state_e state_q, state_d;

  // control
  logic                 out_vld_q, out_vld_d;
  logic [BIN_COUNT-1:0] vld_q;
  logic                 rd_vld_q;
  logic                 cmd_tick_q, cmd_wr_q;
  logic [BW-1:0]        bin_q, bin_d;

  // payload
  logic [LW-1:0] cmd_target_q;
  logic [LW-1:0] t_q, b_q, p_q;
  logic          bar_dn_q, peak_dn_q, peak_up_q;
  logic [LW-1:0] bar_step_q, peak_step_q;
  logic [BW-1:0] out_bin_q;
  logic [OW-1:0] out_bar_q, out_peak_q;
  logic          out_last_q;

  // RAM port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [ENT_W-1:0] rd;
  logic [LW-1:0]    rd_t, rd_b, rd_p;
  logic [LW-1:0]    t_sel, b_sel, p_sel;
  logic             bar_dn, peak_dn, peak_up;
  logic [MUL_W-1:0] bar_mul, peak_mul;
  logic [LW-1:0]    b_new, p_new;
  logic [EXT_W-1:0] b_ext, p_ext;
  logic             out_free, adv, last;
  logic             pop;

  sbpb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  assign rd   = ram_rdata & {ENT_W{rd_vld_q}};
  assign rd_t = rd[3*LW-1:2*LW];
  assign rd_b = rd[2*LW-1:LW];
  assign rd_p = rd[LW-1:0];

  // read stage: set raises to new target; tick scales excess over target, lifts a low peak
  always_comb begin
    t_sel    = cmd_tick_q ? rd_t : cmd_target_q;
    b_sel    = (cmd_wr_q && (cmd_target_q > rd_b)) ? cmd_target_q : rd_b;
    p_sel    = (cmd_wr_q && (cmd_target_q > rd_p)) ? cmd_target_q : rd_p;
    bar_dn   = cmd_tick_q && (rd_b > rd_t);
    peak_dn  = cmd_tick_q && (rd_p > rd_t);
    peak_up  = cmd_tick_q && (rd_p < rd_t);
    bar_mul  = MUL_W'(rd_b - rd_t) * MUL_W'(cfg_i.bar_decay);
    peak_mul = MUL_W'(rd_p - rd_t) * MUL_W'(cfg_i.peak_decay);
  end

  // calc stage: new levels
  always_comb begin
    b_new = bar_dn_q ? t_q + bar_step_q : b_q;
    if (peak_dn_q) begin
      p_new = t_q + peak_step_q;
    end else if (peak_up_q) begin
      p_new = t_q;
    end else begin
      p_new = p_q;
    end
    b_ext = EXT_W'(b_new);
    p_ext = EXT_W'(p_new);
  end

  assign out_free  = !out_vld_q || out_o.ready;
  assign adv       = (state_q == S_CALC) && out_free;
  assign last      = !cmd_tick_q || (bin_q == LAST_BIN);
  assign pop_ready_o = (state_q == S_IDLE);
  assign pop       = pop_valid_i && pop_ready_o;

  assign ram_we    = adv && (cmd_tick_q || cmd_wr_q);
  assign ram_waddr = bin_q[AW-1:0];
  assign ram_wdata = {t_q, b_new, p_new};

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    ram_re    = 1'b0;
    out_vld_d = out_o.ready ? 1'b0 : out_vld_q;
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          bin_d   = pop_ctl_i.tick ? '0 : pop_ctl_i.bin;
          ram_re  = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        if (adv) begin
          out_vld_d = 1'b1;
          if (last) begin
            state_d = S_IDLE;
          end else begin
            bin_d   = bin_q + 1'b1;
            ram_re  = 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_raddr = bin_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      cmd_tick_q <= 1'b0;
      cmd_wr_q   <= 1'b0;
      bin_q      <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      bin_q     <= bin_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (pop) begin
        cmd_tick_q <= pop_ctl_i.tick;
        cmd_wr_q   <= pop_ctl_i.wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_target_q <= pop_target_i;
    end
    if (state_q == S_READ) begin
      t_q         <= t_sel;
      b_q         <= b_sel;
      p_q         <= p_sel;
      bar_dn_q    <= bar_dn;
      peak_dn_q   <= peak_dn;
      peak_up_q   <= peak_up;
      bar_step_q  <= bar_mul[MUL_W-1:sbpb_pkg::DECAY_SHIFT];
      peak_step_q <= peak_mul[MUL_W-1:sbpb_pkg::DECAY_SHIFT];
    end
    if (adv) begin
      out_bin_q  <= bin_q;
      out_bar_q  <= b_ext[OW-1:0];
      out_peak_q <= p_ext[OW-1:0];
      out_last_q <= last;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_bin    = out_bin_q;
  assign out_o.bar_level  = out_bar_q;
  assign out_o.peak_level = out_peak_q;
  assign out_o.last_bin   = out_last_q;

endmodule

[hw/rtl/spectrum_bar_peak_ballistics_top.sv]
// Top level: configuration registers, front classifier, command queue and back sequencer.
// A set request occupies the back sequencer for one read-modify-write of its bin; a tick
// sweeps all BIN_COUNT bins, one read-modify-write of the level RAM per bin, each a read
// state then a calc state that waits for the output register to be free.
// Reset: config registers return to their defaults, per-bin valid bits clear so every
// bin reads as zero at once; no clearing pass, the block takes beats right after reset.
module spectrum_bar_peak_ballistics_top #(
  parameter int unsigned BIN_COUNT     = sbpb_pkg::BIN_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = sbpb_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbpb_in_if.sink    in_i,
  sbpb_out_if.source out_o,
  sbpb_cfg_if.sink   cfg_i
);

  localparam int unsigned LW    = FRACTION_BITS + 1;
  localparam int unsigned CTL_W = $bits(sbpb_pkg::cmd_ctl_t);
  localparam int unsigned Q_W   = CTL_W + LW;

  sbpb_pkg::map_cfg_t   map_cfg_q;
  sbpb_pkg::decay_cfg_t decay_cfg_q;

  sbpb_pkg::cmd_ctl_t front_ctl, back_ctl;
  logic [LW-1:0]      front_target, back_target;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [Q_W-1:0]     pop_data;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cfg_q.floor_level   <= sbpb_pkg::FLOOR_RST;
      map_cfg_q.level_scale   <= sbpb_pkg::SCALE_RST;
      decay_cfg_q.bar_decay   <= sbpb_pkg::BAR_DECAY_RST;
      decay_cfg_q.peak_decay  <= sbpb_pkg::PEAK_DECAY_RST;
    end else if (cfg_i.valid) begin
      case (sbpb_pkg::cfg_reg_e'(cfg_i.index))
        sbpb_pkg::REG_FLOOR_LEVEL: map_cfg_q.floor_level  <= cfg_i.data;
        sbpb_pkg::REG_LEVEL_SCALE: map_cfg_q.level_scale  <= cfg_i.data;
        sbpb_pkg::REG_BAR_DECAY:   decay_cfg_q.bar_decay  <= cfg_i.data;
        sbpb_pkg::REG_PEAK_DECAY:  decay_cfg_q.peak_decay <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  sbpb_front #(
    .BIN_COUNT     (BIN_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_i         (map_cfg_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_ctl_o    (front_ctl),
    .push_target_o (front_target)
  );

  sbpb_fifo #(
    .DW    (Q_W),
    .DEPTH (sbpb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({front_ctl, front_target}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign back_ctl    = sbpb_pkg::cmd_ctl_t'(pop_data[Q_W-1:LW]);
  assign back_target = pop_data[LW-1:0];

  sbpb_back #(
    .BIN_COUNT     (BIN_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_ctl_i    (back_ctl),
    .pop_target_i (back_target),
    .cfg_i        (decay_cfg_q),
    .out_o        (out_o)
  );

endmodule

[hw/rtl/sbpb_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module sbpb_checker #(
  parameter int unsigned BIN_COUNT = sbpb_pkg::BIN_COUNT_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [sbpb_pkg::BIN_W-1:0]       out_bin_i,
  input logic [sbpb_pkg::OUT_LVL_W-1:0]   bar_level_i,
  input logic [sbpb_pkg::OUT_LVL_W-1:0]   peak_level_i,
  input logic                             last_bin_i
);

  localparam logic [sbpb_pkg::BIN_W-1:0] LAST_BIN = sbpb_pkg::BIN_W'(BIN_COUNT - 1);

  logic                       track_q;
  logic [sbpb_pkg::BIN_W-1:0] exp_bin_q;
  logic                       out_beat;

  assign out_beat = out_valid_i && out_ready_i;

  // expected next bin inside a tick sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q   <= 1'b0;
      exp_bin_q <= '0;
    end else if (out_beat) begin
      track_q   <= !last_bin_i;
      exp_bin_q <= out_bin_i + 1'b1;
    end
  end

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bin_i)
      && $stable(bar_level_i) && $stable(peak_level_i) && $stable(last_bin_i))
    else $error("result beat changed while stalled");

  // a beat without the last mark must lie below the final bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_bin_i |-> out_bin_i < LAST_BIN)
    else $error("non-last beat at or past final bin");

  // a tick sweep reports bins in consecutive order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && track_q |-> out_bin_i == exp_bin_q)
    else $error("tick sweep skipped or repeated a bin");

  // no result valid while reset is asserted
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind spectrum_bar_peak_ballistics_top sbpb_checker #(
  .BIN_COUNT (BIN_COUNT)
) u_sbpb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_bin_i    (out_o.out_bin),
  .bar_level_i  (out_o.bar_level),
  .peak_level_i (out_o.peak_level),
  .last_bin_i   (out_o.last_bin)
);
